// ===== rtl/core/knn_pkg.sv =====
package knn_pkg;

    localparam int MaxTrain     = 1024;
    localparam int MaxFeatures  = 16;
    localparam int NumClasses   = 16;
    localparam int MaxK         = 16;
    localparam int FeatureBits  = 16;

    localparam int TrainAw  = $clog2(MaxTrain);
    localparam int FeatAw   = $clog2(MaxFeatures);
    localparam int MemAw    = TrainAw + FeatAw;
    localparam int CntW     = TrainAw + 1;
    localparam int DistW    = 2 * FeatureBits + FeatAw;
    localparam int KAw      = $clog2(MaxK);

    localparam logic [1:0] ModeClear  = 2'd0;
    localparam logic [1:0] ModeTrain  = 2'd1;
    localparam logic [1:0] ModeQuery  = 2'd2;
    localparam logic [1:0] ModeUnused = 2'd3;

    localparam logic [1:0] RegFeatureCount   = 2'd0;
    localparam logic [1:0] RegNeighbourCount = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic signed [15:0] feature_value;
        logic [3:0]  class_label;
    } t_in_item;

    typedef struct packed {
        logic [3:0] predicted_class;
        logic [4:0] winning_votes;
        logic [4:0] neighbours_used;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_VOTE,
        S_OUT
    } t_state;

    // one candidate moving down the sorted cell row
    typedef struct packed {
        logic              valid;
        logic [DistW-1:0]  distance;
        logic [TrainAw-1:0] idx;
        logic [3:0]        label;
    } t_cand;

endpackage

// ===== rtl/core/knn_majority_classifier.sv =====
// Query flow: after the last query element is accepted, the block scans the stored vectors,
//   drains the distance pipeline and cells, votes per class and loads the output (no scan if empty).
// Throughput: one training element per cycle; the last query element raises stall, held
//   through scan, drain and vote until the result is loaded into the output register.
// Reset: synchronous active low; clears the stored count, element position, neighbour
//   cells and handshakes; feature_count returns to 4 and neighbour_count to 3.
module knn_majority_classifier
    import knn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);
    logic [4:0] r_feature_count, r_neighbour_count;
    logic [4:0] w_nf;
    logic [4:0] w_k;
    logic       w_cfg_wr;

    logic [CntW-1:0]   r_count;
    logic [4:0]        r_pos;
    logic              r_partial_q;
    logic [FeatureBits-1:0] r_query [MaxFeatures];

    t_state r_state, n_state;
    logic [TrainAw-1:0] r_vec;
    logic [FeatAw-1:0]  r_feat;
    logic               r_rd_valid, r_rd_last;
    logic [TrainAw-1:0] r_rd_vec;
    logic [FeatAw-1:0]  r_rd_feat;
    logic [DistW-1:0]   r_acc;
    logic [2*FeatureBits-1:0] r_sq;
    logic               r_sq_valid, r_sq_last;
    logic [TrainAw-1:0] r_sq_vec;
    logic [FeatAw-1:0]  r_sq_feat;
    logic               r_new_valid;
    logic [DistW-1:0]   r_new_dist;
    logic [TrainAw-1:0] r_new_idx;
    t_cand              w_new;
    logic [3:0]         w_label_rd;
    logic [5:0]         r_drain;
    logic [4:0]         r_vote_i;
    logic [3:0]         r_win_class;
    logic [4:0]         r_win_votes;
    logic [4:0]         r_used;
    t_out_item          r_out;
    logic               r_out_valid;

    // ---------------- configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            RegFeatureCount[0]:   prdata = {27'd0, r_feature_count};
            RegNeighbourCount[0]: prdata = {27'd0, r_neighbour_count};
            default:              prdata = 32'd0;
        endcase
    end

    assign w_nf = (r_feature_count == 5'd0) ? 5'd1 :
                  (r_feature_count > 5'(MaxFeatures)) ? 5'(MaxFeatures) : r_feature_count;
    always_comb begin
        logic [4:0] k;
        k = (r_neighbour_count == 5'd0) ? 5'd1 :
            (r_neighbour_count > 5'(MaxK)) ? 5'(MaxK) : r_neighbour_count;
        if ({{(CntW-5){1'b0}}, k} > r_count) k = r_count[4:0];
        w_k = k;
    end

    // ---------------- input side
    logic w_in_acc, w_is_q, w_tr, w_last, w_store;
    logic [4:0] w_pos;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_q     = (i_in_data.mode == ModeQuery);
    assign w_tr       = (i_in_data.mode == ModeTrain);
    always_comb begin
        w_pos = r_pos;
        if (r_pos != 5'd0 && r_partial_q != w_is_q) w_pos = 5'd0;
        if (w_pos >= w_nf) w_pos = 5'd0;
    end
    assign w_last  = (w_pos + 5'd1) >= w_nf;
    assign w_store = w_in_acc && w_tr && (r_count < CntW'(MaxTrain));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count   <= 5'd4;
            r_neighbour_count <= 5'd3;
            r_count           <= '0;
            r_pos             <= '0;
            r_partial_q       <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[2] == RegNeighbourCount[0]) begin
                r_neighbour_count <= pwdata[4:0];
            end
            if (w_cfg_wr && paddr[2] == RegFeatureCount[0]) begin
                r_feature_count <= pwdata[4:0];
                r_pos           <= '0;
            end else if (w_in_acc) begin
                if (i_in_data.mode == ModeClear) begin
                    r_count <= '0;
                    r_pos   <= '0;
                end else if (w_tr || w_is_q) begin
                    r_partial_q <= w_is_q;
                    r_pos       <= w_last ? 5'd0 : w_pos + 5'd1;
                    if (w_tr && w_last && r_count < CntW'(MaxTrain)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_q) begin
            r_query[w_pos[FeatAw-1:0]] <= i_in_data.feature_value;
        end
    end

    // ---------------- memories
    logic [FeatureBits-1:0] w_feat_rd;
    logic [3:0] w_lab_in;
    assign w_lab_in = ({1'b0, i_in_data.class_label} >= 5'(NumClasses)) ?
                      4'(NumClasses - 1) : i_in_data.class_label;

    knn_ram #(.Width(FeatureBits), .Depth(MaxTrain * MaxFeatures)) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr ({r_count[TrainAw-1:0], w_pos[FeatAw-1:0]}),
        .i_wdata (i_in_data.feature_value),
        .i_raddr ({r_vec, r_feat}),
        .o_rdata (w_feat_rd)
    );

    knn_ram #(.Width(4), .Depth(MaxTrain)) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (w_store && w_last),
        .i_waddr (r_count[TrainAw-1:0]),
        .i_wdata (w_lab_in),
        .i_raddr (r_sq_vec),
        .o_rdata (w_label_rd)
    );

    // ---------------- sequencer
    logic w_q_done, w_scan_last, w_vote_done;
    assign w_q_done    = w_in_acc && w_is_q && w_last;
    assign w_scan_last = ({{(CntW-TrainAw){1'b0}}, r_vec} == r_count - 1'b1) &&
                         ({1'b0, r_feat} == w_nf - 5'd1);
    assign w_vote_done = (r_vote_i == 5'(NumClasses - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_q_done) n_state = (r_count == '0) ? S_VOTE : S_SCAN;
            S_SCAN:  if (w_scan_last) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 6'(MaxK + 8)) n_state = S_VOTE;
            S_VOTE:  if (w_vote_done) n_state = S_OUT;
            S_OUT:   if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_sq_valid  <= 1'b0;
            r_new_valid <= 1'b0;
            r_vec       <= '0;
            r_feat      <= '0;
            r_drain     <= '0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= (r_state == S_SCAN);
            r_sq_valid  <= r_rd_valid;
            r_new_valid <= r_sq_valid && r_sq_last;
            if (r_state == S_SCAN) begin
                if ({1'b0, r_feat} == w_nf - 5'd1) begin
                    r_feat <= '0;
                    r_vec  <= r_vec + 1'b1;
                end else begin
                    r_feat <= r_feat + 1'b1;
                end
            end else begin
                r_vec  <= '0;
                r_feat <= '0;
            end
            r_drain <= (r_state == S_DRAIN) ? r_drain + 6'd1 : 6'd0;
        end
    end

    // distance pipeline: read, square, accumulate
    logic [FeatureBits:0] w_diff;
    logic [FeatureBits-1:0] w_absd;
    logic [DistW-1:0] w_acc_in;
    assign w_diff = {r_query[r_rd_feat][FeatureBits-1], r_query[r_rd_feat]} -
                    {w_feat_rd[FeatureBits-1], w_feat_rd};
    assign w_absd = w_diff[FeatureBits] ? FeatureBits'(-w_diff) : w_diff[FeatureBits-1:0];
    assign w_acc_in = ((r_sq_feat == '0) ? '0 : r_acc) + DistW'(r_sq);

    always_ff @(posedge i_clk) begin
        r_rd_vec  <= r_vec;
        r_rd_feat <= r_feat;
        r_rd_last <= ({1'b0, r_feat} == w_nf - 5'd1);
        r_sq      <= w_absd * w_absd;
        r_sq_vec  <= r_rd_vec;
        r_sq_feat <= r_rd_feat;
        r_sq_last <= r_rd_last;
        if (r_sq_valid) r_acc <= w_acc_in;
        r_new_dist <= w_acc_in;
        r_new_idx  <= r_sq_vec;
    end
    assign w_new = '{valid: r_new_valid, distance: r_new_dist, idx: r_new_idx,
                     label: w_label_rd};

    // ---------------- neighbour cell row
    t_cand w_chain [MaxK+1];
    t_cand w_held  [MaxK];
    logic  w_clr;
    assign w_clr = w_q_done;
    assign w_chain[0] = w_new;

    for (genvar g = 0; g < MaxK; g++) begin : g_cell
        knn_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_clr    (w_clr),
            .i_enable (5'(g) < w_k),
            .i_cand   (w_chain[g]),
            .o_cand   (w_chain[g+1]),
            .o_held   (w_held[g])
        );
    end

    // ---------------- vote: one class per cycle
    logic [4:0] w_cnt;
    always_comb begin
        w_cnt = '0;
        for (int c = 0; c < MaxK; c++) begin
            if (w_held[c].valid && w_held[c].label == r_vote_i[3:0]) w_cnt = w_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_vote_i    <= '0;
        end else begin
            if (r_state == S_VOTE) begin
                r_vote_i <= r_vote_i + 5'd1;
                if (w_cnt > r_win_votes) begin
                    r_win_votes <= w_cnt;
                    r_win_class <= r_vote_i[3:0];
                end
            end else if (r_state != S_OUT) begin
                r_vote_i    <= '0;
                r_win_votes <= '0;
                r_win_class <= '0;
                r_used      <= w_k;
            end
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_out <= '{predicted_class: r_win_class, winning_votes: r_win_votes,
                           neighbours_used: r_used};
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== rtl/core/knn_ram.sv =====
module knn_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/knn_cell.sv =====
module knn_cell
    import knn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clr,
    input  logic  i_enable,
    input  t_cand i_cand,
    output t_cand o_cand,
    output t_cand o_held
);
    t_cand r_held;
    t_cand r_pass;
    logic  w_take;

    // strict less keeps the earlier (lower index) entry on ties
    assign w_take = i_cand.valid && (!r_held.valid || (i_cand.distance < r_held.distance));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_held.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else if (w_take && i_enable) begin
            r_held <= i_cand;
            r_pass <= r_held;
        end else begin
            r_pass <= i_cand;
        end
    end

    assign o_cand = r_pass;
    assign o_held = r_held;
endmodule
